@@ sv/sdmd_pkg.sv @@
// shared constants and register indexes for the sigma-delta motion detector
`timescale 1ns / 1ps
`default_nettype none

package sdmd_pkg;

   localparam int PIXEL_COUNT = 131072;
   localparam int PIX_W = 8;
   localparam int IDX_W = 17;
   localparam int AMP_W = 4;
   localparam int VAR_W = 8;
   localparam int TGT_W = AMP_W + PIX_W;
   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 8;
   localparam int REQ_DATA_W = 32;
   localparam int RSP_DATA_W = 24;

   localparam logic [CSR_ADDR_W-1:0] CSR_AMPLIFICATION = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_VARIANCE_MIN = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_VARIANCE_MAX = 2'd2;

   localparam logic [AMP_W-1:0] AMPLIFICATION_RESET = 4'd2;
   localparam logic [VAR_W-1:0] VARIANCE_MIN_RESET = 8'd1;
   localparam logic [VAR_W-1:0] VARIANCE_MAX_RESET = 8'd254;

   typedef struct packed {
      logic [PIX_W-1:0] mean;
      logic [VAR_W-1:0] variance;
   } bg_entry_type;

endpackage

`default_nettype wire

@@ sv/sigma_delta_motion_detect_top.sv @@
// sigma-delta background subtraction: per-pixel mean/variance update and motion flag
// One pixel beat is taken every clock while no result waits. A classified pixel is
// offered once its beat has passed through the background memory read, registered
// with the beat, then the mean and difference stage, and then the variance update,
// which loads the write-back and the output register on the same edge. Back-to-back
// pixels with the same index are forwarded around the memory, so any index order is
// allowed. A first-frame beat loads the pixel as mean and variance_min as variance and
// gives no result. The background memory is not cleared; every index must get a
// first-frame beat before it is used. The whole pipeline holds while a result waits.
`timescale 1ns / 1ps
`default_nettype none

module sigma_delta_motion_detect_top (
   input  wire                               clock,
   input  wire                               reset,
   input  wire                               req_tvalid,
   output logic                              req_tready,
   // pixel_value [7:0], pixel_index [24:8], zero fill
   input  wire  [sdmd_pkg::REQ_DATA_W-1:0]   req_tdata,
   // first_frame
   input  wire                               req_tuser,
   output logic                              rsp_tvalid,
   input  wire                               rsp_tready,
   // motion [0], result_index [17:1], zero fill
   output logic [sdmd_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   input  wire                               csr_wen,
   input  wire  [sdmd_pkg::CSR_ADDR_W-1:0]   csr_addr,
   input  wire  [sdmd_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   localparam int PW = sdmd_pkg::PIX_W;
   localparam int IW = sdmd_pkg::IDX_W;
   localparam int VW = sdmd_pkg::VAR_W;
   localparam int TW = sdmd_pkg::TGT_W;

   // configuration
   logic [sdmd_pkg::AMP_W-1:0] amp_ff;
   logic [VW-1:0]              vmin_ff;
   logic [VW-1:0]              vmax_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         amp_ff  <= sdmd_pkg::AMPLIFICATION_RESET;
         vmin_ff <= sdmd_pkg::VARIANCE_MIN_RESET;
         vmax_ff <= sdmd_pkg::VARIANCE_MAX_RESET;
      end else if (csr_wen) begin
         case (csr_addr)
            sdmd_pkg::CSR_AMPLIFICATION: amp_ff  <= csr_wdata[sdmd_pkg::AMP_W-1:0];
            sdmd_pkg::CSR_VARIANCE_MIN:  vmin_ff <= csr_wdata[VW-1:0];
            sdmd_pkg::CSR_VARIANCE_MAX:  vmax_ff <= csr_wdata[VW-1:0];
            default: ;
         endcase
      end
   end

   logic adv;
   logic [PW-1:0] req_pix;
   logic [IW-1:0] req_idx;
   logic          req_in_range;

   assign adv          = !rsp_tvalid || rsp_tready;
   assign req_tready   = adv;
   assign req_pix      = req_tdata[PW-1:0];
   assign req_idx      = req_tdata[PW+IW-1:PW];
   assign req_in_range = {1'b0, req_idx} < (IW+1)'(sdmd_pkg::PIXEL_COUNT);

   // background memory
   sdmd_pkg::bg_entry_type bg_mem_ff [sdmd_pkg::PIXEL_COUNT];
   sdmd_pkg::bg_entry_type rd_data_ff;
   sdmd_pkg::bg_entry_type wr_data;
   logic                   wr_en;

   // stage 1 registers
   logic          p1_valid_ff;
   logic          p1_first_ff;
   logic [PW-1:0] p1_pix_ff;
   logic [IW-1:0] p1_idx_ff;
   logic          byp_hit_ff;
   sdmd_pkg::bg_entry_type byp_data_ff;

   // stage 2 registers
   logic          p2_valid_ff;
   logic          p2_first_ff;
   logic [IW-1:0] p2_idx_ff;
   logic [PW-1:0] p2_mean_ff;
   logic [VW-1:0] p2_var_ff;
   logic [PW-1:0] p2_diff_ff;
   logic [TW-1:0] p2_target_ff;
   logic          wb_valid_ff;
   logic [IW-1:0] wb_idx_ff;
   logic [VW-1:0] wb_var_ff;

   // output registers
   logic          rsp_valid_ff;
   logic          rsp_motion_ff;
   logic [IW-1:0] rsp_idx_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         rd_data_ff <= bg_mem_ff[req_idx];
      end
      if (wr_en) begin
         bg_mem_ff[p2_idx_ff] <= wr_data;
      end
   end

   // stage 1: mean step, difference, target
   logic [PW-1:0] p1_mean_src;
   logic [VW-1:0] p1_var_src;
   logic [PW-1:0] p1_mean_in;
   logic [PW-1:0] p1_diff_in;
   logic [TW-1:0] p1_target_in;

   always_comb begin
      if (p2_valid_ff && (p2_idx_ff == p1_idx_ff)) begin
         p1_mean_src = p2_mean_ff;
      end else if (byp_hit_ff) begin
         p1_mean_src = byp_data_ff.mean;
      end else begin
         p1_mean_src = rd_data_ff.mean;
      end
      p1_var_src = byp_hit_ff ? byp_data_ff.variance : rd_data_ff.variance;

      if (p1_first_ff) begin
         p1_mean_in = p1_pix_ff;
      end else if (p1_mean_src > p1_pix_ff) begin
         p1_mean_in = p1_mean_src - 1'b1;
      end else if (p1_mean_src < p1_pix_ff) begin
         p1_mean_in = p1_mean_src + 1'b1;
      end else begin
         p1_mean_in = p1_mean_src;
      end

      if (p1_pix_ff > p1_mean_in) begin
         p1_diff_in = p1_pix_ff - p1_mean_in;
      end else begin
         p1_diff_in = p1_mean_in - p1_pix_ff;
      end
      p1_target_in = TW'(amp_ff) * TW'(p1_diff_in);
   end

   // stage 2: variance step, clamp, classify
   logic [VW-1:0] p2_var_cur;
   logic [VW-1:0] p2_var_step;
   logic [VW-1:0] p2_var_in;
   logic          p2_motion;

   always_comb begin
      if (wb_valid_ff && (wb_idx_ff == p2_idx_ff)) begin
         p2_var_cur = wb_var_ff;
      end else begin
         p2_var_cur = p2_var_ff;
      end

      if (TW'(p2_var_cur) < p2_target_ff) begin
         p2_var_step = (p2_var_cur == '1) ? p2_var_cur : p2_var_cur + 1'b1;
      end else if (TW'(p2_var_cur) > p2_target_ff) begin
         p2_var_step = p2_var_cur - 1'b1;
      end else begin
         p2_var_step = p2_var_cur;
      end

      if (p2_first_ff) begin
         p2_var_in = vmin_ff;
      end else begin
         p2_var_in = (p2_var_step > vmax_ff) ? vmax_ff : p2_var_step;
         if (p2_var_in < vmin_ff) begin
            p2_var_in = vmin_ff;
         end
      end
      p2_motion = p2_diff_ff >= p2_var_in;
   end

   assign wr_en            = adv && p2_valid_ff;
   assign wr_data.mean     = p2_mean_ff;
   assign wr_data.variance = p2_var_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_valid_ff  <= 1'b0;
         p2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         byp_hit_ff   <= 1'b0;
         wb_valid_ff  <= 1'b0;
      end else if (adv) begin
         p1_valid_ff  <= req_tvalid && req_in_range;
         p2_valid_ff  <= p1_valid_ff;
         rsp_valid_ff <= p2_valid_ff && !p2_first_ff;
         byp_hit_ff   <= wr_en && (p2_idx_ff == req_idx);
         wb_valid_ff  <= wr_en;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         p1_first_ff   <= req_tuser;
         p1_pix_ff     <= req_pix;
         p1_idx_ff     <= req_idx;
         byp_data_ff   <= wr_data;
         p2_first_ff   <= p1_first_ff;
         p2_idx_ff     <= p1_idx_ff;
         p2_mean_ff    <= p1_mean_in;
         p2_var_ff     <= p1_var_src;
         p2_diff_ff    <= p1_diff_in;
         p2_target_ff  <= p1_target_in;
         wb_idx_ff     <= p2_idx_ff;
         wb_var_ff     <= p2_var_in;
         rsp_motion_ff <= p2_motion;
         rsp_idx_ff    <= p2_idx_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {(sdmd_pkg::RSP_DATA_W-IW-1)'(0), rsp_idx_ff, rsp_motion_ff};

endmodule

`default_nettype wire

@@ sv/sdmd_checker.sv @@
// port-level checks for the sigma-delta motion detector, bound to the top level
`timescale 1ns / 1ps
`default_nettype none

module sdmd_checker (
   input wire                             clock,
   input wire                             reset,
   input wire                             req_tready,
   input wire                             rsp_tvalid,
   input wire                             rsp_tready,
   input wire [sdmd_pkg::RSP_DATA_W-1:0]  rsp_tdata
);

   localparam int USED_W = sdmd_pkg::IDX_W + 1;

   a_reset_clears_rsp: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result beat valid after reset");

   a_stall_blocks_req: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |-> !req_tready)
      else $error("pixel beat taken while result stalled");

   a_rsp_holds: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result beat changed");

   a_fill_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[sdmd_pkg::RSP_DATA_W-1:USED_W] == '0))
      else $error("result fill bits not zero");

endmodule

bind sigma_delta_motion_detect_top sdmd_checker u_sdmd_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire
